[rtl/core/hes_pkg.sv]
// Package for the Hencky energy and stress pipeline.
// Holds fixed-point widths, constants and a saturation function; depends on nothing.
`default_nettype none
package hes_pkg;
   localparam int DIMENSION = 3;
   localparam int LOG_FRAC_BITS = 20;
   localparam int DIV_BITS = 64;
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [0:0] CSR_SHEAR = 1'b0;
   localparam logic [0:0] CSR_LAME = 1'b1;

   // clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
      if (v > 96'sh7FFFFFFF) begin
         return SAT_MAX;
      end else if (v < -96'sh80000000) begin
         return SAT_MIN;
      end
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

[rtl/core/hes_ln.sv]
// Pipelined natural log of a positive Q16.16 value: one squaring step per stage.
// Depends on hes_pkg.
`default_nettype none
module hes_ln (
   input  wire logic clock,
   input  wire logic [31:0] x,
   output logic signed [31:0] ln_out
);
   import hes_pkg::*;

   logic [31:0] m_ff [0:LOG_FRAC_BITS];
   logic [LOG_FRAC_BITS-1:0] f_ff [0:LOG_FRAC_BITS];
   logic signed [5:0] p_ff [0:LOG_FRAC_BITS];
   logic signed [26:0] l2_ff;
   logic signed [57:0] prod_ff;
   logic [4:0] p_c;
   logic [31:0] m0_c;

   // find the leading one
   always_comb begin
      p_c = 5'd0;
      for (int i = 1; i <= 30; i++) begin
         if (x[i]) begin
            p_c = 5'(i);
         end
      end
      m0_c = 32'(x << (5'd30 - p_c));
   end

   always_ff @(posedge clock) begin
      m_ff[0] <= m0_c;
      f_ff[0] <= '0;
      p_ff[0] <= $signed({1'b0, p_c}) - 6'sd16;
   end

   // one fraction bit per stage
   for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_step
      logic [63:0] sq_c;
      assign sq_c = (64'(m_ff[k]) * 64'(m_ff[k])) >> 30;
      always_ff @(posedge clock) begin
         p_ff[k+1] <= p_ff[k];
         if (sq_c[31]) begin
            m_ff[k+1] <= sq_c[32:1];
            f_ff[k+1] <= {f_ff[k][LOG_FRAC_BITS-2:0], 1'b1};
         end else begin
            m_ff[k+1] <= sq_c[31:0];
            f_ff[k+1] <= {f_ff[k][LOG_FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   // scale log2 by ln 2, then round to Q16.16
   always_ff @(posedge clock) begin
      l2_ff <= {p_ff[LOG_FRAC_BITS][5], p_ff[LOG_FRAC_BITS], f_ff[LOG_FRAC_BITS]};
      prod_ff <= 58'(l2_ff) * $signed({1'b0, LN2_Q30});
   end
   logic signed [57:0] rnd_c;
   assign rnd_c = (prod_ff + 58'sd8589934592) >>> 34;
   assign ln_out = rnd_c[31:0];
endmodule
`default_nettype wire

[rtl/core/hencky_energy_and_stress.sv]
// Top level of the Hencky energy and stress pipeline.
// Depends on hes_pkg and hes_ln.
`default_nettype none
// Fully pipelined: one item per cycle and busy stays low. The result of an item
// transferred by start reaches the rsp_ ports through an input register, the log
// (setup, 20 squaring stages and scaling), four product and sum stages, then a
// 64-stage restoring divider, one quotient bit per stage, with one load stage.
// rsp_valid pulses once per item; the receiver cannot stall.
module hencky_energy_and_stress (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic signed [31:0] req_sigma_a,
   input  wire logic signed [31:0] req_sigma_b,
   input  wire logic signed [31:0] req_sigma_c,
   output logic rsp_valid,
   output logic signed [31:0] rsp_energy,
   output logic signed [31:0] rsp_stress_a,
   output logic signed [31:0] rsp_stress_b,
   output logic signed [31:0] rsp_stress_c,
   output logic rsp_inverted,
   input  wire logic csr_we,
   input  wire logic [0:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   import hes_pkg::*;

   localparam int LN_LAT = LOG_FRAC_BITS + 3;
   localparam int LAT = LN_LAT + 6 + DIV_BITS;

   logic signed [31:0] mu_ff, lam_ff;
   logic [LAT-1:0] vld_ff;
   logic signed [31:0] sig_ff [0:LN_LAT+4][0:2];
   logic inv_ff [0:LAT-1];
   logic signed [31:0] ln_c [0:2];

   assign busy = 1'b0;

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff <= 32'sd65536;
         lam_ff <= 32'sd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHEAR: mu_ff <= csr_wdata;
            CSR_LAME: lam_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   // delay the singular values and inverted flag alongside the logs
   always_ff @(posedge clock) begin
      sig_ff[0][0] <= req_sigma_a;
      sig_ff[0][1] <= req_sigma_b;
      sig_ff[0][2] <= req_sigma_c;
      inv_ff[0] <= (req_sigma_a <= 0) || (req_sigma_b <= 0)
                   || ((DIMENSION == 3) && (req_sigma_c <= 0));
      for (int s = 1; s <= LN_LAT + 4; s++) begin
         sig_ff[s] <= sig_ff[s-1];
      end
      for (int s = 1; s < LAT; s++) begin
         inv_ff[s] <= inv_ff[s-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_ln
      hes_ln u_ln (.clock(clock), .x(sig_ff[0][i]), .ln_out(ln_c[i]));
   end

   // stage A: logs, sum, squares
   logic signed [31:0] l_ff [0:2];
   logic signed [33:0] t_ff;
   logic signed [65:0] sq_ff;
   logic signed [31:0] la_c [0:2];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         la_c[i] = (i < DIMENSION) ? ln_c[i] : 32'sd0;
      end
   end
   always_ff @(posedge clock) begin
      l_ff <= la_c;
      t_ff <= 34'(la_c[0]) + 34'(la_c[1]) + 34'(la_c[2]);
      sq_ff <= 66'(la_c[0]) * 66'(la_c[0]) + 66'(la_c[1]) * 66'(la_c[1])
               + 66'(la_c[2]) * 66'(la_c[2]);
   end

   // stage B: S, T2 and per-lane 2*mu*l
   logic signed [27:0] s_ff;
   logic signed [27:0] t2_ff;
   logic signed [33:0] tb_ff;
   logic signed [64:0] ml_ff [0:2];
   logic signed [67:0] t2w_c;
   assign t2w_c = (68'(t_ff) * 68'(t_ff) + 68'sd32768) >>> 16;
   always_ff @(posedge clock) begin
      s_ff <= 28'((sq_ff + 66'sd32768) >>> 16);
      t2_ff <= t2w_c[27:0];
      tb_ff <= t_ff;
      for (int i = 0; i < 3; i++) begin
         ml_ff[i] <= (65'(mu_ff) * 65'(l_ff[i])) <<< 1;
      end
   end

   // stage C: weighted products
   logic signed [95:0] em_ff, el_ff;
   logic signed [66:0] lt_ff;
   logic signed [64:0] mlc_ff [0:2];
   always_ff @(posedge clock) begin
      em_ff <= (96'(mu_ff) * 96'(s_ff)) <<< 1;
      el_ff <= 96'(lam_ff) * 96'(t2_ff);
      lt_ff <= 67'(lam_ff) * 67'(tb_ff);
      mlc_ff <= ml_ff;
   end

   // stage D: energy, numerator magnitude and sign
   logic signed [31:0] e_ff [0:DIV_BITS+1];
   logic [DIV_BITS-1:0] num_ff [0:2];
   logic neg_ff [0:2];
   logic signed [96:0] esum_c;
   assign esum_c = (97'(em_ff) + 97'(el_ff) + 97'sd65536) >>> 17;
   always_ff @(posedge clock) begin
      e_ff[0] <= sat32(esum_c[95:0]);
      for (int i = 0; i < 3; i++) begin
         logic signed [67:0] n;
         logic [67:0] mag;
         n = 68'(mlc_ff[i]) + 68'(lt_ff);
         mag = n[67] ? 68'(-n) : 68'(n);
         neg_ff[i] <= n[67];
         num_ff[i] <= mag[63:0] + {33'd0, sig_ff[LN_LAT+3][i][31:1]};
      end
   end

   // restoring divider lanes, one quotient bit per stage
   logic [DIV_BITS-1:0] dq_ff [0:2][0:DIV_BITS];
   logic [31:0] dr_ff [0:2][0:DIV_BITS];
   logic [31:0] dd_ff [0:2][0:DIV_BITS];
   logic dn_ff [0:2][0:DIV_BITS];
   for (genvar i = 0; i < 3; i++) begin : g_div
      always_ff @(posedge clock) begin
         dq_ff[i][0] <= num_ff[i];
         dr_ff[i][0] <= '0;
         dd_ff[i][0] <= sig_ff[LN_LAT+4][i];
         dn_ff[i][0] <= neg_ff[i];
      end
      for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
         logic [32:0] r_c;
         assign r_c = {dr_ff[i][k], dq_ff[i][k][DIV_BITS-1]};
         always_ff @(posedge clock) begin
            dd_ff[i][k+1] <= dd_ff[i][k];
            dn_ff[i][k+1] <= dn_ff[i][k];
            if (r_c >= {1'b0, dd_ff[i][k]}) begin
               dr_ff[i][k+1] <= 32'(r_c - {1'b0, dd_ff[i][k]});
               dq_ff[i][k+1] <= {dq_ff[i][k][DIV_BITS-2:0], 1'b1};
            end else begin
               dr_ff[i][k+1] <= r_c[31:0];
               dq_ff[i][k+1] <= {dq_ff[i][k][DIV_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= DIV_BITS + 1; k++) begin
         e_ff[k] <= e_ff[k-1];
      end
   end

   // saturate and select output
   logic signed [31:0] st_c [0:2];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [DIV_BITS-1:0] q;
         q = dq_ff[i][DIV_BITS];
         if (dn_ff[i][DIV_BITS]) begin
            st_c[i] = (q >= 64'h80000000) ? SAT_MIN : 32'(-q[31:0]);
         end else begin
            st_c[i] = (q > 64'h7FFFFFFF) ? SAT_MAX : q[31:0];
         end
         if (inv_ff[LAT-1] || (i >= DIMENSION)) begin
            st_c[i] = 32'sd0;
         end
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_inverted = inv_ff[LAT-1];
   assign rsp_energy = inv_ff[LAT-1] ? SAT_MAX : e_ff[DIV_BITS + 1];
   assign rsp_stress_a = st_c[0];
   assign rsp_stress_b = st_c[1];
   assign rsp_stress_c = st_c[2];

`ifndef NO_ASSERTIONS
   a_inv_energy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inverted |-> rsp_energy == SAT_MAX && rsp_stress_a == 0)
      else $error("inverted result not saturated");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[LAT-2]))
      else $error("valid pipeline broken");
`endif
endmodule
`default_nettype wire
